@@ rtl/core/rwcb_pkg.sv @@
`default_nettype none

package rwcb_pkg;

	// Default number of table entries
	localparam int DEFAULT_DEPTH = 16;

	localparam logic [15:0] FULL_MASK = 16'hFFFF;

	// Input modes
	localparam logic [1:0] MODE_MODIFY = 2'd0;
	localparam logic [1:0] MODE_FLUSH  = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_WRITE  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_BUSY  = 2'd2;
	localparam logic [1:0] ST_ORDER = 2'd3;

	// One table entry
	typedef struct packed {
		logic [15:0] addr;
		logic [15:0] mask;
		logic [15:0] bits;
	} entry_t;

	// Build the mask of bits lsb..msb
	function automatic logic [15:0] field_mask(input logic [3:0] msb, input logic [3:0] lsb);
		logic [15:0] m;
		for (int j = 0; j < 16; j++) begin
			m[j] = (4'(j) >= lsb) && (4'(j) <= msb);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/rwcb_table_ram.sv @@
`default_nettype none

module rwcb_table_ram import rwcb_pkg::*; #(
	parameter int DEPTH = DEFAULT_DEPTH,
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [IW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic          re,
	input  wire logic [IW-1:0] raddr,
	output entry_t             rdata
);

	entry_t entry_mem_q [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			entry_mem_q[waddr] <= wdata;
		end
	end

	// Read one entry, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= entry_mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/register_write_coalescing_buffer_core.sv @@
// Sequencing: a status-only answer goes through the status state once the item is taken; a modify
//   reads and examines each entry searched, then answers with a status; a flush or read-data item reads
//   and examines each table entry walked, at most two walks, plus output stalls.
// Throughput: one item at a time, set by the single table read port walked entry by entry.
// Reset: arst_n clears the entry count, flush state, read cursor and sequencer at once;
//   table contents are not cleared and are only read below the entry count.
`default_nettype none

module register_write_coalescing_buffer_core import rwcb_pkg::*; #(
	parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] reg_address,
	input  wire logic [3:0]  field_msb,
	input  wire logic [3:0]  field_lsb,
	input  wire logic [15:0] field_value,
	input  wire logic [15:0] read_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [1:0]       status,
	output logic [31:0]      spi_word,
	output logic             last
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_RD, S_EX, S_STAT} state_t;
	typedef enum logic [2:0] {OP_FIND, OP_LAST, OP_RDCMD, OP_FILL, OP_NEXT, OP_WRITES} op_t;

	state_t        state_q;
	op_t           op_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] cursor_q;
	logic [CW-1:0] lastp_q;
	logic          pending_q;
	logic          anyp_q;
	logic [15:0]   addr_q;
	logic [15:0]   fmask_q;
	logic [15:0]   fval_q;
	logic [15:0]   rdat_q;
	logic [1:0]    stcode_q;
	logic          out_valid_q;
	logic [1:0]    kind_q;
	logic [1:0]    status_q;
	logic [31:0]   spi_word_q;
	logic          last_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic          ram_re;
	entry_t        ent;
	logic          idx_end;
	logic          partial;
	logic          out_free;
	logic          out_load;
	logic [CW-1:0] idx_nx;
	logic [15:0]   in_mask;

	rwcb_table_ram #(.DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q[IW-1:0]),
		.rdata (ent)
	);

	assign idx_end  = (idx_q >= count_q);
	assign partial  = (ent.mask != FULL_MASK);
	assign out_free = !out_valid_q || !out_stall;
	assign idx_nx   = idx_q + CW'(1);
	assign in_mask  = field_mask(field_msb, field_lsb);
	assign ram_re   = (state_q == S_RD) && !idx_end;
	assign in_stall = (state_q != S_IDLE);

	// Flag a cycle that loads a new result into the output register
	assign out_load = out_free && ((state_q == S_STAT)
		|| (state_q == S_EX && op_q == OP_RDCMD && partial)
		|| (state_q == S_EX && op_q == OP_WRITES));

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign status    = status_q;
	assign spi_word  = spi_word_q;
	assign last      = last_q;

	// Select the table write: new entry, merged field, or filled read data
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[IW-1:0];
		ram_wdata = ent;
		if (state_q == S_RD && idx_end && op_q == OP_FIND && count_q < DEPTH_C) begin
			ram_we    = 1'b1;
			ram_waddr = count_q[IW-1:0];
			ram_wdata = '{addr: addr_q, mask: fmask_q, bits: fval_q};
		end else if (state_q == S_EX && op_q == OP_FIND && ent.addr == addr_q) begin
			ram_we    = 1'b1;
			ram_wdata = '{addr: ent.addr, mask: ent.mask | fmask_q,
				bits: (ent.bits & ~fmask_q) | fval_q};
		end else if (state_q == S_EX && op_q == OP_FILL && partial) begin
			ram_we    = 1'b1;
			ram_wdata = '{addr: ent.addr, mask: FULL_MASK,
				bits: (rdat_q & ~ent.mask) | ent.bits};
		end
	end

	// Sequence the table walks and drive the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_FIND;
			idx_q       <= '0;
			count_q     <= '0;
			cursor_q    <= '0;
			lastp_q     <= '0;
			pending_q   <= 1'b0;
			anyp_q      <= 1'b0;
			addr_q      <= '0;
			fmask_q     <= '0;
			fval_q      <= '0;
			rdat_q      <= '0;
			stcode_q    <= ST_OK;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_STATUS;
			status_q    <= ST_OK;
			spi_word_q  <= '0;
			last_q      <= 1'b0;
		end else begin
			// Drop the result once taken
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						addr_q  <= reg_address;
						fmask_q <= in_mask;
						fval_q  <= (field_value << field_lsb) & in_mask;
						rdat_q  <= read_data;
						anyp_q  <= 1'b0;
						priority if (mode == MODE_MODIFY && !pending_q) begin
							if (field_msb < field_lsb) begin
								stcode_q <= ST_ORDER;
								state_q  <= S_STAT;
							end else begin
								op_q    <= OP_FIND;
								idx_q   <= '0;
								state_q <= S_RD;
							end
						end else if (mode == MODE_FLUSH && !pending_q) begin
							if (count_q == '0) begin
								stcode_q <= ST_OK;
								state_q  <= S_STAT;
							end else begin
								op_q    <= OP_LAST;
								idx_q   <= '0;
								state_q <= S_RD;
							end
						end else if (mode == MODE_READ && pending_q) begin
							op_q    <= OP_FILL;
							idx_q   <= cursor_q;
							state_q <= S_RD;
						end else begin
							stcode_q <= ST_BUSY;
							state_q  <= S_STAT;
						end
					end
				end
				S_RD: begin
					if (!idx_end) begin
						state_q <= S_EX;
					end else begin
						// End of a walk
						unique case (op_q)
							OP_FIND: begin
								if (count_q < DEPTH_C) begin
									count_q  <= count_q + CW'(1);
									stcode_q <= ST_OK;
								end else begin
									stcode_q <= ST_FULL;
								end
								state_q <= S_STAT;
							end
							OP_LAST: begin
								op_q  <= anyp_q ? OP_RDCMD : OP_WRITES;
								idx_q <= '0;
							end
							OP_RDCMD: begin
								pending_q <= 1'b1;
								cursor_q  <= '0;
								state_q   <= S_IDLE;
							end
							OP_FILL, OP_NEXT: begin
								op_q  <= OP_WRITES;
								idx_q <= '0;
							end
							OP_WRITES: begin
								count_q   <= '0;
								pending_q <= 1'b0;
								cursor_q  <= '0;
								state_q   <= S_IDLE;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_EX: begin
					unique case (op_q)
						OP_FIND: begin
							if (ent.addr == addr_q) begin
								stcode_q <= ST_OK;
								state_q  <= S_STAT;
							end else begin
								idx_q   <= idx_nx;
								state_q <= S_RD;
							end
						end
						OP_LAST: begin
							if (partial) begin
								anyp_q  <= 1'b1;
								lastp_q <= idx_q;
							end
							idx_q   <= idx_nx;
							state_q <= S_RD;
						end
						OP_RDCMD: begin
							if (!partial) begin
								idx_q   <= idx_nx;
								state_q <= S_RD;
							end else if (out_free) begin
								out_valid_q <= 1'b1;
								kind_q      <= KIND_READ;
								status_q    <= ST_OK;
								spi_word_q  <= {1'b0, ent.addr[14:0], 16'h0000};
								last_q      <= (idx_q == lastp_q);
								if (idx_q == lastp_q) begin
									pending_q <= 1'b1;
									cursor_q  <= '0;
									state_q   <= S_IDLE;
								end else begin
									idx_q   <= idx_nx;
									state_q <= S_RD;
								end
							end
						end
						OP_FILL: begin
							if (partial) begin
								cursor_q <= idx_nx;
								op_q     <= OP_NEXT;
							end
							idx_q   <= idx_nx;
							state_q <= S_RD;
						end
						OP_NEXT: begin
							if (partial) begin
								stcode_q <= ST_OK;
								state_q  <= S_STAT;
							end else begin
								idx_q   <= idx_nx;
								state_q <= S_RD;
							end
						end
						OP_WRITES: begin
							if (out_free) begin
								out_valid_q <= 1'b1;
								kind_q      <= KIND_WRITE;
								status_q    <= ST_OK;
								spi_word_q  <= {1'b1, ent.addr[14:0], ent.bits};
								last_q      <= (idx_nx == count_q);
								if (idx_nx == count_q) begin
									count_q   <= '0;
									pending_q <= 1'b0;
									cursor_q  <= '0;
									state_q   <= S_IDLE;
								end else begin
									idx_q   <= idx_nx;
									state_q <= S_RD;
								end
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_STAT: begin
					// Emit the single status item
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_STATUS;
						status_q    <= stcode_q;
						spi_word_q  <= '0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/rwcb_checker.sv @@
`default_nettype none

module rwcb_checker import rwcb_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  kind,
	input wire logic [1:0]  status,
	input wire logic [31:0] spi_word,
	input wire logic        last
);

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(spi_word) && $stable(kind)
			&& $stable(last))
		else $error("stalled result changed");

	// Stall input in the cycle after taking an item
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on consecutive cycles");

	// Status-only items are single, last, and carry no word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATUS |-> last && spi_word == 32'h0)
		else $error("malformed status item");

	// Command words carry status ok and the right write flag
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_STATUS |-> status == ST_OK
			&& ((kind == KIND_READ && !spi_word[31] && spi_word[15:0] == 16'h0)
			|| (kind == KIND_WRITE && spi_word[31])))
		else $error("malformed command item");

endmodule

bind register_write_coalescing_buffer_core rwcb_checker u_rwcb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.kind      (kind),
	.status    (status),
	.spi_word  (spi_word),
	.last      (last)
);

`default_nettype wire
